>>> src/mqtd_pkg.sv
// Package for the multi-port tail-drop queue with congestion marking.
// Holds widths, action and status codes, and the front-to-back command type.
// No dependencies.
package mqtd_pkg;
   localparam int NumPorts    = 16;
   localparam int NumBuffers  = 1024;
   localparam int PortW       = 4;
   localparam int BufW        = 10;
   localparam int CountW      = 11;
   localparam int HandleW     = 32;
   localparam int RegW        = 11;
   localparam int CsrIdxW     = 1;

   localparam logic [1:0] ActEnq   = 2'd0;
   localparam logic [1:0] ActDeq   = 2'd1;
   localparam logic [1:0] ActOpen  = 2'd2;
   localparam logic [1:0] ActClose = 2'd3;

   localparam logic [3:0] StQueued   = 4'd0;
   localparam logic [3:0] StFull     = 4'd1;
   localparam logic [3:0] StNoBuf    = 4'd2;
   localparam logic [3:0] StUnknown  = 4'd3;
   localparam logic [3:0] StDequeued = 4'd4;
   localparam logic [3:0] StEmpty    = 4'd5;
   localparam logic [3:0] StOpened   = 4'd6;
   localparam logic [3:0] StAlready  = 4'd7;
   localparam logic [3:0] StClosed   = 4'd8;

   localparam logic [RegW-1:0] LimitReset  = RegW'(100);
   localparam logic [RegW-1:0] ThreshReset = RegW'(50);

   localparam logic [CsrIdxW-1:0] RegLimit  = 1'b0;
   localparam logic [CsrIdxW-1:0] RegThresh = 1'b1;

   typedef struct packed {
      logic [1:0]         action;
      logic [PortW-1:0]   port;
      logic [HandleW-1:0] handle;
   } cmd_type;
endpackage

>>> src/mqtd_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
// Depends on mqtd_pkg.
module mqtd_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mqtd_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output mqtd_pkg::cmd_type out_cmd
);
   import mqtd_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end
endmodule

>>> src/mqtd_engine.sv
// Back part: per-port queue state, link and handle memories, free list.
// Each command reads the memories, then updates state. Depends on mqtd_pkg.
module mqtd_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  mqtd_pkg::cmd_type             cmd,
   input  logic [mqtd_pkg::RegW-1:0]     queue_limit,
   input  logic [mqtd_pkg::RegW-1:0]     congestion_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_status,
   output logic [mqtd_pkg::HandleW-1:0]  rsp_handle_out,
   output logic                          rsp_ecn_mark,
   output logic [mqtd_pkg::CountW-1:0]   rsp_queue_count
);
   import mqtd_pkg::*;

   typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_type;

   state_type           state_ff;
   logic [BufW-1:0]     init_ff;
   cmd_type             cur_ff;

   logic [NumPorts-1:0] open_ff;
   logic [CountW-1:0]   count_ff [NumPorts];
   logic [BufW-1:0]     head_ff [NumPorts];
   logic [BufW-1:0]     tail_ff [NumPorts];
   logic [BufW-1:0]     free_head_ff, free_tail_ff;
   logic [CountW-1:0]   free_count_ff;

   logic [BufW-1:0]     link_mem [NumBuffers];
   logic [HandleW-1:0]  hstore_mem [NumBuffers];
   logic [BufW-1:0]     link_rd_ff;   // link of the head buffer involved
   logic [HandleW-1:0]  hstore_rd_ff;

   logic                out_valid_ff;
   logic [3:0]          out_status_ff;
   logic [HandleW-1:0]  out_handle_ff;
   logic                out_ecn_ff;
   logic [CountW-1:0]   out_count_ff;

   logic [BufW-1:0]     rd_addr;
   logic                link_we;
   logic [BufW-1:0]     link_wa, link_wd;
   logic [PortW-1:0]    p;
   logic [CountW-1:0]   pc, pc_dec;

   assign cmd_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_handle_out  = out_handle_ff;
   assign rsp_ecn_mark    = out_ecn_ff;
   assign rsp_queue_count = out_count_ff;

   assign p      = cur_ff.port;
   assign pc     = count_ff[p];
   assign pc_dec = pc - CountW'(1);

   // Read address: dequeue follows the port head, enqueue the free head.
   assign rd_addr = (cmd.action == ActDeq) ? head_ff[cmd.port] : free_head_ff;

   always_ff @(posedge clock) begin
      link_rd_ff   <= link_mem[rd_addr];
      hstore_rd_ff <= hstore_mem[rd_addr];
   end

   // At most one link write per command; the init sweep chains the free list.
   always_comb begin
      link_we = 1'b0;
      link_wa = init_ff;
      link_wd = init_ff + BufW'(1);
      if (state_ff == S_INIT) begin
         link_we = 1'b1;
      end else if (state_ff == S_EXEC && open_ff[p]) begin
         case (cur_ff.action)
            ActEnq: begin
               if (pc < queue_limit && free_count_ff != '0 && pc != '0) begin
                  link_we = 1'b1;
                  link_wa = tail_ff[p];
                  link_wd = free_head_ff;
               end
            end
            ActDeq: begin
               if (pc != '0) begin
                  link_we = 1'b1;
                  link_wa = head_ff[p];
                  link_wd = free_head_ff;
               end
            end
            ActClose: begin
               if (pc != '0 && free_count_ff != '0) begin
                  link_we = 1'b1;
                  link_wa = free_tail_ff;
                  link_wd = head_ff[p];
               end
            end
            default: link_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (state_ff == S_EXEC && cur_ff.action == ActEnq && open_ff[p]
          && pc < queue_limit && free_count_ff != '0) begin
         hstore_mem[free_head_ff] <= cur_ff.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ff       <= '0;
         open_ff       <= '0;
         free_head_ff  <= '0;
         free_tail_ff  <= BufW'(NumBuffers - 1);
         free_count_ff <= CountW'(NumBuffers);
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < NumPorts; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + BufW'(1);
               if (init_ff == BufW'(NumBuffers - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cur_ff   <= cmd;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff      <= S_IDLE;
               out_valid_ff  <= 1'b1;
               out_status_ff <= StUnknown;
               out_handle_ff <= '0;
               out_ecn_ff    <= 1'b0;
               out_count_ff  <= '0;
               if (cur_ff.action == ActOpen) begin
                  if (open_ff[p]) begin
                     out_status_ff <= StAlready;
                     out_count_ff  <= pc;
                  end else begin
                     open_ff[p]    <= 1'b1;
                     count_ff[p]   <= '0;
                     out_status_ff <= StOpened;
                  end
               end else if (open_ff[p]) begin
                  case (cur_ff.action)
                     ActEnq: begin
                        out_count_ff <= pc;
                        if (pc >= queue_limit) begin
                           out_status_ff <= StFull;
                        end else if (free_count_ff == '0) begin
                           out_status_ff <= StNoBuf;
                        end else begin
                           free_head_ff  <= link_rd_ff;
                           free_count_ff <= free_count_ff - CountW'(1);
                           if (pc == '0) begin
                              head_ff[p] <= free_head_ff;
                           end
                           tail_ff[p]    <= free_head_ff;
                           count_ff[p]   <= pc + CountW'(1);
                           out_count_ff  <= pc + CountW'(1);
                           out_status_ff <= StQueued;
                        end
                     end
                     ActDeq: begin
                        out_count_ff <= pc;
                        if (pc == '0) begin
                           out_status_ff <= StEmpty;
                        end else begin
                           out_handle_ff <= hstore_rd_ff;
                           head_ff[p]    <= link_rd_ff;
                           count_ff[p]   <= pc_dec;
                           out_count_ff  <= pc_dec;
                           free_head_ff  <= head_ff[p];
                           if (free_count_ff == '0) begin
                              free_tail_ff <= head_ff[p];
                           end
                           free_count_ff <= free_count_ff + CountW'(1);
                           out_ecn_ff    <= (pc_dec > congestion_threshold);
                           out_status_ff <= StDequeued;
                        end
                     end
                     default: begin
                        if (pc != '0) begin
                           if (free_count_ff == '0) begin
                              free_head_ff <= head_ff[p];
                           end
                           free_tail_ff  <= tail_ff[p];
                           free_count_ff <= free_count_ff + pc;
                        end
                        count_ff[p]   <= '0;
                        open_ff[p]    <= 1'b0;
                        out_status_ff <= StClosed;
                     end
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> src/multi_port_queue_tail_drop_ecn.sv
// Top level of the multi-port tail-drop queue with congestion marking.
// Instantiates the command queue and the engine; depends on mqtd_pkg.
//
// Usage:
//   The req_ channel carries one action (enqueue, dequeue, open, close) for a
//   port and an optional packet handle. Every request yields exactly one
//   result on the rsp_ channel: status, dequeued handle, ECN mark and the
//   port's entry count after the action.
//   The csr_ channel writes queue_limit (index 0) and congestion_threshold
//   (index 1); write only while no request is in flight.
//   The engine takes a request from the command queue (memory read),
//   then updates its state, and only takes the next request once the
//   result register has drained.
//   After reset the engine chains all 1024 buffers into the free list;
//   requests queue up in the two-entry command queue and then stall.
//   A stalled receiver holds the result register; the command queue keeps
//   taking up to two more requests before req_ready falls.
module multi_port_queue_tail_drop_ecn (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [mqtd_pkg::PortW-1:0]          req_port,
   input  logic [mqtd_pkg::HandleW-1:0]        req_packet_handle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [3:0]                          rsp_status,
   output logic [mqtd_pkg::HandleW-1:0]        rsp_handle_out,
   output logic                                rsp_ecn_mark,
   output logic [mqtd_pkg::CountW-1:0]         rsp_queue_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mqtd_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [mqtd_pkg::RegW-1:0]           csr_data
);
   import mqtd_pkg::*;

   cmd_type           req_cmd, q_cmd;
   logic              q_valid, q_ready;
   logic [RegW-1:0]   limit_ff, thresh_ff;

   assign req_cmd   = '{action: req_action, port: req_port, handle: req_packet_handle};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LimitReset;
         thresh_ff <= ThreshReset;
      end else if (csr_valid) begin
         if (csr_index == RegLimit) begin
            limit_ff <= csr_data;
         end
         if (csr_index == RegThresh) begin
            thresh_ff <= csr_data;
         end
      end
   end

   mqtd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (req_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   mqtd_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (q_valid),
      .cmd_ready            (q_ready),
      .cmd                  (q_cmd),
      .queue_limit          (limit_ff),
      .congestion_threshold (thresh_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_handle_out       (rsp_handle_out),
      .rsp_ecn_mark         (rsp_ecn_mark),
      .rsp_queue_count      (rsp_queue_count)
   );
endmodule

>>> src/mqtd_checker.sv
// Port-level checker for the multi-port tail-drop queue, bound to the top.
// Depends on mqtd_pkg.
module mqtd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [3:0]                    rsp_status,
   input logic [mqtd_pkg::HandleW-1:0]  rsp_handle_out,
   input logic                          rsp_ecn_mark,
   input logic [mqtd_pkg::CountW-1:0]   rsp_queue_count
);
   import mqtd_pkg::*;

   // A stalled result holds its status.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");

   a_ecn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ecn_mark |-> rsp_status == StDequeued)
      else $error("ECN mark outside a dequeue");

   a_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StDequeued |-> rsp_handle_out == '0)
      else $error("handle on a non-dequeue result");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == StUnknown || rsp_status == StClosed
                    || rsp_status == StOpened) |-> rsp_queue_count == '0)
      else $error("nonzero count on an empty-queue result");
endmodule

bind multi_port_queue_tail_drop_ecn mqtd_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_handle_out  (rsp_handle_out),
   .rsp_ecn_mark    (rsp_ecn_mark),
   .rsp_queue_count (rsp_queue_count)
);
